// ===== rtl/i2r_pkg.sv =====
// i2r_pkg: widths, character codes and helpers for the integer to radix digit converter
// no dependencies; imported by every module of the block
package i2r_pkg;

  localparam int VALUE_BITS = 64;
  localparam int RADIX_BITS = 6;
  localparam int CHAR_BITS  = 7;

  // divider retires this many quotient bits per clock
  localparam int STEP_BITS  = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORD_BITS  = DIV_STEPS * STEP_BITS;
  localparam int CNT_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

  localparam logic [RADIX_BITS-1:0] DIGIT_MAX  = RADIX_BITS'(9);
  localparam logic [CHAR_BITS-1:0]  LETTER_GAP = CHAR_BITS'(7);
  localparam logic [CHAR_BITS-1:0]  CH_ZERO    = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0]  CH_MINUS   = CHAR_BITS'(45);

  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MAX_MAG  = ~SIGN_BIT;

  typedef struct packed {
    logic                  done;
    logic [RADIX_BITS-1:0] rem;
  } div_status_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    c = CHAR_BITS'(d) + CH_ZERO;
    if (d > DIGIT_MAX) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

// ===== rtl/i2r_divider.sv =====
// i2r_divider: shared restoring divider, magnitude by radix, STEP_BITS quotient bits per clock
// depends on i2r_pkg
module i2r_divider
  import i2r_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_BITS-1:0] divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output div_status_t           status
);

  logic                  active;
  logic                  done;
  logic [CNT_BITS-1:0]   cnt;
  logic [WORD_BITS-1:0]  word;
  logic [RADIX_BITS-1:0] rem;
  logic [RADIX_BITS-1:0] dvs;

  logic [WORD_BITS-1:0]  word_next;
  logic [RADIX_BITS-1:0] rem_next;
  logic [RADIX_BITS:0]   trial;

  // shift in one dividend bit, subtract when the partial remainder reaches the divisor
  always_comb begin
    word_next = word;
    rem_next  = rem;
    trial     = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial     = {rem_next, word_next[WORD_BITS-1]};
      word_next = {word_next[WORD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial        = trial - {1'b0, dvs};
        word_next[0] = 1'b1;
      end
      rem_next = trial[RADIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_BITS'(DIV_STEPS - 1);
      end else if (active) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word <= WORD_BITS'(dividend);
      rem  <= '0;
      dvs  <= divisor;
    end else if (active) begin
      word <= word_next;
      rem  <= rem_next;
    end
  end

  assign quotient    = word[VALUE_BITS-1:0];
  assign status.done = done;
  assign status.rem  = rem;

endmodule

// ===== rtl/integer_to_radix_digits.sv =====
// integer_to_radix_digits: top level, sequencer around the shared radix divider
// depends on i2r_pkg and i2r_divider
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  request  | start in, busy out    | value[63:0], radix[5:0]
//  result   | strobe out, one cycle | digit_char[6:0], last
//
// each digit is one pass through the shared divider, which retires
// 8 quotient bits per clock; a negative value adds a final '-' character
// a request gives at most 63 binary digits and the sign
// busy is high from the accepting edge until the edge that shows the last character
// synchronous reset clears the sequencer and the strobe; results are never held off
module integer_to_radix_digits
  import i2r_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [63:0]           value,
  input  logic [RADIX_BITS-1:0] radix,
  output logic                  strobe,
  output logic [CHAR_BITS-1:0]  digit_char,
  output logic                  last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;

  logic [1:0]            state;
  logic                  negative;
  logic [RADIX_BITS-1:0] base;

  logic [VALUE_BITS-1:0] v;
  logic                  v_neg;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_BITS-1:0] radix_clamp;

  logic                  accept;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_BITS-1:0] div_divisor;
  logic [VALUE_BITS-1:0] quotient;
  div_status_t           div_st;
  logic                  more;

  assign v     = value[VALUE_BITS-1:0];
  assign v_neg = v[VALUE_BITS-1];

  // most negative value saturates to the largest magnitude
  always_comb begin
    if (!v_neg) begin
      mag = v;
    end else if (v == SIGN_BIT) begin
      mag = MAX_MAG;
    end else begin
      mag = ~v + VALUE_BITS'(1);
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamp = RADIX_MAX;
    end else begin
      radix_clamp = radix;
    end
  end

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign more         = (quotient != '0);
  assign div_start    = accept || ((state == ST_RUN) && div_st.done && more);
  assign div_dividend = (state == ST_IDLE) ? mag : quotient;
  assign div_divisor  = (state == ST_IDLE) ? radix_clamp : base;

  i2r_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (div_st.done) begin
            strobe <= 1'b1;
            if (!more) begin
              state <= negative ? ST_SIGN : ST_IDLE;
            end
          end
        end
        ST_SIGN: begin
          strobe <= 1'b1;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= v_neg;
      base     <= radix_clamp;
    end
    if (state == ST_RUN && div_st.done) begin
      digit_char <= digit_to_ascii(div_st.rem);
      last       <= !more && !negative;
    end else if (state == ST_SIGN) begin
      digit_char <= CH_MINUS;
      last       <= 1'b1;
    end
  end

endmodule

// ===== rtl/i2r_checker.sv =====
// i2r_checker: port-level checks for integer_to_radix_digits, bound to the top level
// depends on i2r_pkg
module i2r_checker
  import i2r_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [63:0]           value,
  input logic [RADIX_BITS-1:0] radix,
  input logic                  strobe,
  input logic [CHAR_BITS-1:0]  digit_char,
  input logic                  last
);

  // the final character releases the block in the same cycle
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high on final character");

  // characters before the final one only come while a request is open
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final character outside a request");

  // an accepted request keeps the block busy directly after the accept
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy)
    else $error("busy dropped right after accept");

  // the minus sign closes a conversion
  a_minus_last: assert property (@(posedge clk) disable iff (rst)
    strobe && digit_char == CH_MINUS |-> last)
    else $error("minus sign not marked last");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char == CH_MINUS)
               || (digit_char >= 7'd48 && digit_char <= 7'd57)
               || (digit_char >= 7'd65 && digit_char <= 7'd90))
    else $error("character outside digit set");

endmodule

bind integer_to_radix_digits i2r_checker u_chk (.*);

// ===== tb/i2r_digit_checker.sv =====
// i2r_digit_checker: watches the request and character channels of integer_to_radix_digits,
// predicts the character string of each accepted request and compares it as it arrives
// depends on i2r_pkg for widths and character codes
`timescale 1ns / 1ps

module i2r_digit_checker
  import i2r_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [63:0]           value,
  input  logic [RADIX_BITS-1:0] radix,
  input  logic                  strobe,
  input  logic [CHAR_BITS-1:0]  digit_char,
  input  logic                  last,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 fin;
  } radix_char_t;

  radix_char_t expected_chars[$];

  function automatic void predict_digits(input logic [63:0] val, input logic [RADIX_BITS-1:0] rdx);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [RADIX_BITS-1:0] rem;
    logic                  neg;
    radix_char_t           c;
    int                    n;
    v    = val[VALUE_BITS-1:0];
    neg  = v[VALUE_BITS-1];
    base = VALUE_BITS'(rdx);
    n    = 0;
    if (base < 2) begin
      base = 2;
    end
    if (base > 36) begin
      base = 36;
    end
    mag = neg ? (~v + 1'b1) : v;
    // magnitude of the most negative value saturates
    if (neg && mag[VALUE_BITS-1]) begin
      mag = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
    if (mag == 0) begin
      c.ch  = CH_ZERO;
      c.fin = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    while (mag != 0 && n < 64) begin
      rem   = RADIX_BITS'(mag % base);
      c.ch  = CH_ZERO + CHAR_BITS'(rem) + ((rem > 9) ? CHAR_BITS'(7) : CHAR_BITS'(0));
      c.fin = 1'b0;
      expected_chars.push_back(c);
      mag = mag / base;
      n++;
    end
    if (neg && n < 64) begin
      c.ch  = CH_MINUS;
      c.fin = 1'b0;
      expected_chars.push_back(c);
    end
    expected_chars[expected_chars.size()-1].fin = 1'b1;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    radix_char_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_digits(value, radix);
      end
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, got digit_char %h last %b",
                   $time, digit_char, last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (digit_char !== want.ch) begin
            $display("%0t: digit_char mismatch, expected %h got %h", $time, want.ch, digit_char);
            errors++;
          end
          if (last !== want.fin) begin
            $display("%0t: last mismatch, expected %b got %b", $time, want.fin, last);
            errors++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ===== tb/integer_to_radix_digits_tb.sv =====
// integer_to_radix_digits_tb: drives directed and random conversion requests into the block
// with random idle gaps or, in some runs, none; i2r_digit_checker predicts and compares the characters
// depends on i2r_pkg, integer_to_radix_digits and i2r_digit_checker
`timescale 1ns / 1ps

module integer_to_radix_digits_tb;
  import i2r_pkg::*;

  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [63:0]           value = '0;
  logic [RADIX_BITS-1:0] radix = RADIX_BITS'(2);
  logic                  strobe;
  logic [CHAR_BITS-1:0]  digit_char;
  logic                  last;
  int                    errors;
  int                    pending;
  bit                    no_idle = 1'b0;

  always #6 clk = ~clk;

  integer_to_radix_digits i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .radix      (radix),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  i2r_digit_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .radix      (radix),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last),
    .errors     (errors),
    .pending    (pending)
  );

  task automatic send_conversion(input logic [63:0] val, input logic [RADIX_BITS-1:0] rdx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      value = {$urandom, $urandom};
      radix = RADIX_BITS'($urandom);
    end
    @(negedge clk);
    start = 1'b1;
    value = val;
    radix = rdx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int          kind;
    int          guard;
    logic [63:0] val;
    logic [5:0]  rdx;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_conversion(64'd0, 6'd10);
    send_conversion(64'd0, 6'd0);
    send_conversion(64'd1, 6'd2);
    send_conversion(-64'sd1, 6'd10);
    send_conversion(MOST_POS, 6'd2);
    send_conversion(MOST_NEG, 6'd2);
    send_conversion(MOST_NEG, 6'd36);
    send_conversion(MOST_POS, 6'd36);
    send_conversion(MOST_NEG + 64'd1, 6'd10);
    send_conversion(64'd35, 6'd36);
    send_conversion(64'd10, 6'd11);
    send_conversion(64'd9, 6'd10);
    send_conversion(64'd36, 6'd36);
    send_conversion(64'd5, 6'd1);
    send_conversion(64'd255, 6'd37);
    send_conversion(-64'sd12345, 6'd63);
    send_conversion(64'h0123_4567_89AB_CDEF, 6'd16);
    send_conversion(-64'sd255, 6'd16);
    send_conversion(64'd1000, 6'd7);
    send_conversion(MOST_NEG, 6'd0);

    for (int i = 0; i < 380; i++) begin
      if (i % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 9);
      val  = {$urandom, $urandom};
      case (kind)
        4, 5: val = val >> $urandom_range(1, 63);
        6:    val = -(val >> $urandom_range(1, 63));
        7:    val = ($urandom_range(0, 1) == 1) ? -64'($urandom_range(0, 5000))
                                                : 64'($urandom_range(0, 5000));
        8: begin
          case ($urandom_range(0, 4))
            0: val = 64'd0;
            1: val = 64'd1;
            2: val = -64'sd1;
            3: val = MOST_POS;
            default: val = MOST_NEG;
          endcase
        end
        default: ;
      endcase
      rdx = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(2, 36));
      send_conversion(val, rdx);
    end

    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("integer_to_radix_digits test passed");
    end else begin
      $display("integer_to_radix_digits test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("integer_to_radix_digits test failed");
    $finish;
  end

endmodule

// ===== integer_to_radix_digits.f =====
rtl/i2r_pkg.sv
rtl/i2r_divider.sv
rtl/integer_to_radix_digits.sv
rtl/i2r_checker.sv
tb/i2r_digit_checker.sv
tb/integer_to_radix_digits_tb.sv
